// ----- sv/hbl_pkg.sv -----
package hbl_pkg;

	// command codes
	localparam logic [2:0] KIND_HUE    = 3'd0;
	localparam logic [2:0] KIND_DIM    = 3'd1;
	localparam logic [2:0] KIND_MAX    = 3'd2;
	localparam logic [2:0] KIND_OFF    = 3'd3;
	localparam logic [2:0] KIND_ADJUST = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_DIM_STEP    = 2'd0;
	localparam logic [1:0] REG_MAX_LEVEL   = 2'd1;
	localparam logic [1:0] REG_START_LEVEL = 2'd2;

	// configuration reset values
	localparam logic [7:0] DIM_STEP_RST    = 8'd4;
	localparam logic [7:0] MAX_LEVEL_RST   = 8'd240;
	localparam logic [7:0] START_LEVEL_RST = 8'd120;

	// colour channel codes, in wire order
	localparam logic [1:0] CH_GREEN = 2'd0;
	localparam logic [1:0] CH_RED   = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] hue;
		logic signed [7:0]  delta;
	} in_t;

	typedef struct packed {
		logic [7:0] led_byte;
		logic       byte_valid;
		logic [7:0] led_index;
		logic [1:0] channel;
		logic       last;
		logic [7:0] brightness;
	} out_t;

	// request to the shared scaling unit
	typedef struct packed {
		logic       valid;
		logic [1:0] tag;
		logic [7:0] x;
		logic [7:0] lvl;
	} scl_req_t;

	// result from the shared scaling unit
	typedef struct packed {
		logic       valid;
		logic [1:0] tag;
		logic [7:0] q;
	} scl_res_t;

endpackage

// ----- sv/hbl_scale.sv -----
// shared scaler: q = (x * lvl) / 255, two stages
module hbl_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  hbl_pkg::scl_req_t req,
	output hbl_pkg::scl_res_t res
);

	logic        v_s1, v_s2;
	logic [1:0]  tag_s1, tag_s2;
	logic [15:0] p_s1;
	logic [7:0]  q_s2;
	logic [16:0] sum;

	// exact divide by 255 for any product of two 8-bit values
	assign sum = 17'(p_s1) + 17'(p_s1[15:8]) + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= req.tag;
		p_s1   <= 16'(req.x) * 16'(req.lvl);
		tag_s2 <= tag_s1;
		q_s2   <= sum[15:8];
	end

	assign res.valid = v_s2;
	assign res.tag   = tag_s2;
	assign res.q     = q_s2;

endmodule

// ----- sv/hue_brightness_led_frame_top.sv -----
// colour controller for a chain of addressable leds
// input channel: in_valid / in_stall carry one command item (kind, hue, delta).
// in_stall is high whenever a command is in progress; one item at a time.
// output channel: out_valid / out_stall carry result items from an output
// register. a hue, dim or off command gives LED_COUNT*3 byte items in
// green, red, blue order per led; max and adjust give one status item.
// sequence: a frame command scales its three channel bytes through one shared
// two-stage multiplier, then loads the scaled bytes into the output register
// one byte a cycle while out_stall does not hold it; the next command is taken
// only after the last byte is loaded. a status command goes straight to the
// send state and loads its one status item. the single output register and
// the byte sequencer set this order.
// stall: while out_stall is high the current item holds and the sequencer
// waits; nothing is dropped.
// reset: level and base colour clear to zero, registers return to
// dim_step 4, max_level 240, start_level 120; no item pending.
// config: cfg_we with cfg_index and cfg_data; the user must write these only while idle, the block does not enforce it
module hue_brightness_led_frame_top #(
	parameter int LED_COUNT = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hbl_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output hbl_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	localparam int LW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_SEND} state_t;

	state_t state_q;

	// configuration
	logic [7:0] dim_step_q, max_level_q, start_level_q;

	// block state
	logic [7:0] level_q, base_r_q, base_g_q, base_b_q;

	// scaled frame bytes
	logic [7:0] scl_r_q, scl_g_q, scl_b_q;

	// sequencing
	logic          status_q;
	logic [1:0]    iss_q;
	logic [LW-1:0] led_q;
	logic [1:0]    ch_q;

	logic          out_valid_q;
	hbl_pkg::out_t out_q;

	hbl_pkg::scl_req_t req;
	hbl_pkg::scl_res_t res;

	logic              accept;
	logic              load_ok;
	logic              frame_last;
	logic [23:0]       hue_rgb_w;
	logic signed [9:0] dim_sum, adj_sum;
	logic [7:0]        dim_lvl, adj_lvl, send_byte;
	logic [7:0]        scl_x;

	// hue to six-sector base colour, {r, g, b}
	function automatic logic [23:0] hue_rgb(input logic signed [15:0] h);
		logic [8:0] hv;
		logic [2:0] sec;
		logic [5:0] f;
		logic [9:0] up_m, dn_m;
		logic [7:0] up, dn;
		logic [23:0] rgb;
		hv = (h[15] || h >= 16'sd360) ? 9'd0 : h[8:0];
		if (hv >= 9'd300) begin
			sec = 3'd5; f = 6'(hv - 9'd300);
		end else if (hv >= 9'd240) begin
			sec = 3'd4; f = 6'(hv - 9'd240);
		end else if (hv >= 9'd180) begin
			sec = 3'd3; f = 6'(hv - 9'd180);
		end else if (hv >= 9'd120) begin
			sec = 3'd2; f = 6'(hv - 9'd120);
		end else if (hv >= 9'd60) begin
			sec = 3'd1; f = 6'(hv - 9'd60);
		end else begin
			sec = 3'd0; f = hv[5:0];
		end
		// 255/60 is 17/4
		up_m = 10'(f) * 10'd17;
		dn_m = (10'd60 - 10'(f)) * 10'd17;
		up   = up_m[9:2];
		dn   = dn_m[9:2];
		case (sec)
			3'd0:    rgb = {8'd255, up, 8'd0};
			3'd1:    rgb = {dn, 8'd255, 8'd0};
			3'd2:    rgb = {8'd0, 8'd255, up};
			3'd3:    rgb = {8'd0, dn, 8'd255};
			3'd4:    rgb = {up, 8'd0, 8'd255};
			default: rgb = {8'd255, 8'd0, dn};
		endcase
		return rgb;
	endfunction

	// clamp to 1..255
	function automatic logic [7:0] clamp_lvl(input logic signed [9:0] v);
		logic [7:0] c;
		if (v < 10'sd1)
			c = 8'd1;
		else if (v > 10'sd255)
			c = 8'd255;
		else
			c = v[7:0];
		return c;
	endfunction

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	assign hue_rgb_w = hue_rgb(in_data.hue);

	assign dim_sum = $signed({2'b00, level_q}) - $signed({2'b00, dim_step_q});
	assign adj_sum = $signed({2'b00, level_q}) + $signed({{2{in_data.delta[7]}}, in_data.delta});
	// dim to a level below 2 acts as off
	assign dim_lvl = (clamp_lvl(dim_sum) < 8'd2) ? 8'd0 : clamp_lvl(dim_sum);
	assign adj_lvl = clamp_lvl(adj_sum);

	// issue green, red, blue to the shared scaler; off frames scale by zero
	assign req.valid = (state_q == ST_SCALE) && (iss_q != 2'd3);
	assign req.tag   = iss_q;
	assign req.lvl   = level_q;
	assign req.x     = scl_x;
	always_comb begin
		case (iss_q)
			hbl_pkg::CH_GREEN: scl_x = base_g_q;
			hbl_pkg::CH_RED:   scl_x = base_r_q;
			default:           scl_x = base_b_q;
		endcase
	end

	hbl_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always_comb begin
		case (ch_q)
			hbl_pkg::CH_GREEN: send_byte = scl_g_q;
			hbl_pkg::CH_RED:   send_byte = scl_r_q;
			default:           send_byte = scl_b_q;
		endcase
	end

	assign frame_last = (led_q == LW'(LED_COUNT - 1)) && (ch_q == hbl_pkg::CH_BLUE);
	assign load_ok    = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			dim_step_q    <= hbl_pkg::DIM_STEP_RST;
			max_level_q   <= hbl_pkg::MAX_LEVEL_RST;
			start_level_q <= hbl_pkg::START_LEVEL_RST;
			level_q       <= 8'd0;
			base_r_q      <= 8'd0;
			base_g_q      <= 8'd0;
			base_b_q      <= 8'd0;
			scl_r_q       <= 8'd0;
			scl_g_q       <= 8'd0;
			scl_b_q       <= 8'd0;
			status_q      <= 1'b0;
			iss_q         <= 2'd0;
			led_q         <= '0;
			ch_q          <= 2'd0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hbl_pkg::REG_DIM_STEP:    dim_step_q    <= cfg_data;
					hbl_pkg::REG_MAX_LEVEL:   max_level_q   <= cfg_data;
					hbl_pkg::REG_START_LEVEL: start_level_q <= cfg_data;
					default: ;
				endcase
			end

			// next item loaded, or the held one taken
			if ((state_q == ST_SEND) && load_ok)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_q <= 2'd0;
						led_q <= '0;
						ch_q  <= hbl_pkg::CH_GREEN;
						unique case (in_data.kind)
							hbl_pkg::KIND_HUE: begin
								if (level_q == 8'd0)
									level_q <= start_level_q;
								base_r_q <= hue_rgb_w[23:16];
								base_g_q <= hue_rgb_w[15:8];
								base_b_q <= hue_rgb_w[7:0];
								status_q <= 1'b0;
								state_q  <= ST_SCALE;
							end
							hbl_pkg::KIND_DIM: begin
								level_q  <= dim_lvl;
								status_q <= 1'b0;
								state_q  <= ST_SCALE;
							end
							hbl_pkg::KIND_MAX: begin
								level_q  <= max_level_q;
								status_q <= 1'b1;
								state_q  <= ST_SEND;
							end
							hbl_pkg::KIND_OFF: begin
								level_q  <= 8'd0;
								status_q <= 1'b0;
								state_q  <= ST_SCALE;
							end
							hbl_pkg::KIND_ADJUST: begin
								level_q  <= adj_lvl;
								status_q <= 1'b1;
								state_q  <= ST_SEND;
							end
							default: ;  // unused kinds are dropped
						endcase
					end
				end
				ST_SCALE: begin
					if (req.valid)
						iss_q <= iss_q + 2'd1;
					if (res.valid) begin
						case (res.tag)
							hbl_pkg::CH_GREEN: scl_g_q <= res.q;
							hbl_pkg::CH_RED:   scl_r_q <= res.q;
							default:           scl_b_q <= res.q;
						endcase
						// blue comes back last
						if (res.tag == hbl_pkg::CH_BLUE)
							state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (load_ok) begin
						if (status_q) begin
							out_q.led_byte   <= 8'd0;
							out_q.byte_valid <= 1'b0;
							out_q.led_index  <= 8'd0;
							out_q.channel    <= hbl_pkg::CH_GREEN;
							out_q.last       <= 1'b1;
							out_q.brightness <= level_q;
							state_q          <= ST_IDLE;
						end else begin
							out_q.led_byte   <= send_byte;
							out_q.byte_valid <= 1'b1;
							out_q.led_index  <= 8'(led_q);
							out_q.channel    <= ch_q;
							out_q.last       <= frame_last;
							out_q.brightness <= level_q;
							if (frame_last) begin
								state_q <= ST_IDLE;
							end else if (ch_q == hbl_pkg::CH_BLUE) begin
								ch_q  <= hbl_pkg::CH_GREEN;
								led_q <= led_q + LW'(1);
							end else begin
								ch_q <= ch_q + 2'd1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
